// ----- hdl/tod_pkg.sv -----
// ----------------------------------------------------------------------------
// tod_pkg
// Shared types, constants and constant-divisor helpers for the time-of-day
// clock.
// ----------------------------------------------------------------------------
`default_nettype none

package tod_pkg;

  localparam int unsigned HoursPerDay      = 24;
  localparam int unsigned MinutesPerHour   = 60;
  localparam int unsigned SecondsPerMinute = 60;
  localparam int unsigned TenthsPerSecond  = 10;

  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;
  localparam int unsigned TenthW  = 4;
  localparam int unsigned SetW    = 8;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_SET  = 1'b1
  } op_t;

  typedef struct packed {
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [TenthW-1:0]  tenth;
  } time_t;

  // x / 10 for x <= 255: multiply by 205 / 2048, exact over that range.
  function automatic logic [4:0] div10(input logic [SetW-1:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd205;
    return p[15:11];
  endfunction

  // x / 60 for x < 300: count the multiples of 60 that fit.
  function automatic logic [2:0] div60(input logic [8:0] x);
    logic [2:0] q;
    q = 3'(x >= 9'd60) + 3'(x >= 9'd120) + 3'(x >= 9'd180) + 3'(x >= 9'd240);
    return q;
  endfunction

  // x / 24 for x < 260: multiply by 171 / 4096, exact over that range.
  function automatic logic [3:0] div24(input logic [8:0] x);
    logic [15:0] p;
    p = 16'(x) * 16'd171;
    return p[15:12];
  endfunction

endpackage

`default_nettype wire

// ----- hdl/tod_step.sv -----
// ----------------------------------------------------------------------------
// tod_step
// Next-time logic: advance one tenth with cascaded carries, or load and
// normalize a time from tenths up to hours.
// ----------------------------------------------------------------------------
`default_nettype none

module tod_step (
  input  tod_pkg::time_t                cur,
  input  tod_pkg::op_t                  op,
  input  logic [tod_pkg::SetW-1:0]      set_hour,
  input  logic [tod_pkg::SetW-1:0]      set_minute,
  input  logic [tod_pkg::SetW-1:0]      set_second,
  input  logic [tod_pkg::SetW-1:0]      set_tenth,
  output tod_pkg::time_t                nxt,
  output logic                          day
);
  import tod_pkg::*;

  logic    tenth_wrap, second_wrap, minute_wrap, hour_wrap;
  time_t   tick_time;
  time_t   set_time;
  logic [4:0] q_tenth;
  logic [8:0] sec_sum, min_sum, hour_sum;
  logic [2:0] q_sec, q_min;
  logic [3:0] q_hour;
  logic [7:0] tenth_rem;
  logic [8:0] sec_rem, min_rem, hour_rem;

  // Tick: carry ripples upward through each wrapping digit.
  always_comb begin
    tenth_wrap  = (cur.tenth == TenthW'(TenthsPerSecond - 1));
    second_wrap = tenth_wrap && (cur.second == SecondW'(SecondsPerMinute - 1));
    minute_wrap = second_wrap && (cur.minute == MinuteW'(MinutesPerHour - 1));
    hour_wrap   = minute_wrap && (cur.hour == HourW'(HoursPerDay - 1));

    tick_time.tenth  = tenth_wrap  ? '0 : cur.tenth + 1'b1;
    tick_time.second = !tenth_wrap ? cur.second : (second_wrap ? '0 : cur.second + 1'b1);
    tick_time.minute = !second_wrap ? cur.minute : (minute_wrap ? '0 : cur.minute + 1'b1);
    tick_time.hour   = !minute_wrap ? cur.hour : (hour_wrap ? '0 : cur.hour + 1'b1);
  end

  // Set: normalize by constant divisors, carrying each quotient upward.
  always_comb begin
    q_tenth   = div10(set_tenth);
    tenth_rem = set_tenth - 8'(q_tenth) * 8'(TenthsPerSecond);

    sec_sum   = 9'(set_second) + 9'(q_tenth);
    q_sec     = div60(sec_sum);
    sec_rem   = sec_sum - 9'(q_sec) * 9'(SecondsPerMinute);

    min_sum   = 9'(set_minute) + 9'(q_sec);
    q_min     = div60(min_sum);
    min_rem   = min_sum - 9'(q_min) * 9'(MinutesPerHour);

    hour_sum  = 9'(set_hour) + 9'(q_min);
    q_hour    = div24(hour_sum);
    hour_rem  = hour_sum - 9'(q_hour) * 9'(HoursPerDay);

    set_time.tenth  = tenth_rem[TenthW-1:0];
    set_time.second = sec_rem[SecondW-1:0];
    set_time.minute = min_rem[MinuteW-1:0];
    set_time.hour   = hour_rem[HourW-1:0];
  end

  always_comb begin
    unique case (op)
      OP_SET: begin
        nxt = set_time;
        day = 1'b0;
      end
      OP_TICK: begin
        nxt = tick_time;
        day = hour_wrap;
      end
      default: begin
        nxt = tick_time;
        day = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/time_of_day_clock.sv -----
// ----------------------------------------------------------------------------
// time_of_day_clock
// Hours, minutes, seconds and tenths clock driven by tick and set beats.
// ----------------------------------------------------------------------------
// Each input beat is either a tick (operation 0), which advances the clock by
// one tenth of a second and carries up through seconds, minutes and hours, or
// a set (operation 1), which loads the four set fields and normalizes them,
// with any carry past 24 hours dropped. Every input beat produces exactly one
// output beat carrying the time after that beat; day_rollover is high only on
// the result of a tick that wrapped 23:59:59.9 to midnight. The block takes one
// beat per cycle while the output side keeps up: a beat lands in the input
// register, the next-time logic runs on it combinationally, and the result
// register, which is also the clock state, loads it. A beat thus passes
// through the input register and then the result register. The time is
// 00:00:00.0 after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module time_of_day_clock (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           operation,
  input  logic [tod_pkg::SetW-1:0]       set_hour,
  input  logic [tod_pkg::SetW-1:0]       set_minute,
  input  logic [tod_pkg::SetW-1:0]       set_second,
  input  logic [tod_pkg::SetW-1:0]       set_tenth,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tod_pkg::HourW-1:0]      hour,
  output logic [tod_pkg::MinuteW-1:0]    minute,
  output logic [tod_pkg::SecondW-1:0]    second,
  output logic [tod_pkg::TenthW-1:0]     tenth,
  output logic                           day_rollover
);
  import tod_pkg::*;

  // Input register.
  logic             s1_valid;
  op_t              s1_op;
  logic [SetW-1:0]  s1_set_hour;
  logic [SetW-1:0]  s1_set_minute;
  logic [SetW-1:0]  s1_set_second;
  logic [SetW-1:0]  s1_set_tenth;

  // Clock state, which is also the result register.
  time_t  now;
  time_t  now_next;
  logic   day_next;
  logic   out_free;
  logic   s1_move;

  // Advance the result register when it is empty or being drained.
  assign out_free = !out_valid || out_ready;
  assign s1_move  = s1_valid && out_free;
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  // Payload: hold while the stage is stalled.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op         <= op_t'(operation);
      s1_set_hour   <= set_hour;
      s1_set_minute <= set_minute;
      s1_set_second <= set_second;
      s1_set_tenth  <= set_tenth;
    end
  end

  tod_step u_step (
    .cur        (now),
    .op         (s1_op),
    .set_hour   (s1_set_hour),
    .set_minute (s1_set_minute),
    .set_second (s1_set_second),
    .set_tenth  (s1_set_tenth),
    .nxt        (now_next),
    .day        (day_next)
  );

  // Update the clock state only when a beat moves into the result register,
  // so the next beat always sees the time left by the one before it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      now          <= '0;
      day_rollover <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (s1_move) begin
        now          <= now_next;
        day_rollover <= day_next;
      end
    end
  end

  assign hour   = now.hour;
  assign minute = now.minute;
  assign second = now.second;
  assign tenth  = now.tenth;

  // The held time is always a legal time of day.
  a_time_legal: assert property (@(posedge clk) disable iff (rst)
    (now.hour < HourW'(HoursPerDay)) && (now.minute < MinuteW'(MinutesPerHour)) &&
    (now.second < SecondW'(SecondsPerMinute)) && (now.tenth < TenthW'(TenthsPerSecond)))
    else $error("time_of_day_clock: clock state out of range");

  // A day rollover only ever lands on midnight.
  a_rollover_midnight: assert property (@(posedge clk) disable iff (rst)
    day_rollover |-> (now == '0))
    else $error("time_of_day_clock: day rollover without midnight");

  // A tick that does not wrap the tenth bumps it by one and leaves the rest.
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (s1_move && (s1_op == OP_TICK) && (now.tenth != TenthW'(TenthsPerSecond - 1)))
    |=> (now.tenth == $past(now.tenth) + 1'b1) && $stable(now.second) &&
        $stable(now.minute) && $stable(now.hour) && !day_rollover)
    else $error("time_of_day_clock: tick did not advance the tenth");

  // A set never raises the day flag.
  a_set_no_rollover: assert property (@(posedge clk) disable iff (rst)
    (s1_move && (s1_op == OP_SET)) |=> !day_rollover)
    else $error("time_of_day_clock: set raised day rollover");

  // The state changes only when a beat moves into the result register.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_move |=> $stable(now))
    else $error("time_of_day_clock: clock state changed without a beat");

endmodule

`default_nettype wire
